FILE: rtl/sel_pkg.sv
// Shared types, codes and constants for the serial escape line front end.
package sel_pkg;

  localparam int unsigned CountWidth      = 11;
  localparam int unsigned DefLineCapacity = 1024;
  localparam int unsigned MaxResults      = 3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_ROW  = 2'd2,
    PH_COL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    K_ECHO     = 3'd0,
    K_RESPONSE = 3'd1,
    K_APPEND   = 3'd2,
    K_DELETE   = 3'd3,
    K_LINE_END = 3'd4,
    K_BREAK    = 3'd5,
    K_RESET    = 3'd6
  } kind_t;

  localparam logic [6:0] C_ESC      = 7'h1b;
  localparam logic [6:0] C_SPACE    = 7'h20;
  localparam logic [6:0] C_BS       = 7'h08;
  localparam logic [6:0] C_TAB      = 7'h09;
  localparam logic [6:0] C_LF       = 7'h0a;
  localparam logic [6:0] C_CR       = 7'h0d;
  localparam logic [6:0] C_RESP_LO  = 7'h08;
  localparam logic [6:0] C_RESP_HI  = 7'h10;
  localparam logic [6:0] C_PSEND_ON = 7'h11;
  localparam logic [6:0] C_PSEND_OF = 7'h12;
  localparam logic [6:0] C_ECHO_ON  = 7'h13;
  localparam logic [6:0] C_ECHO_OF  = 7'h14;
  localparam logic [6:0] C_CAPS_ON  = 7'h15;
  localparam logic [6:0] C_CAPS_OF  = 7'h16;
  localparam logic [6:0] C_TIMER_OF = 7'h17;
  localparam logic [6:0] C_RESET    = 7'h18;
  localparam logic [6:0] C_CURSOR_Y = 7'h59;
  localparam logic [6:0] C_CURSOR_E = 7'h3d;

  typedef struct packed {
    phase_t                  phase;
    logic                    echo;
    logic                    psend;
    logic                    caps;
    logic                    timer;
    logic [CountWidth-1:0]   line_count;
    logic [CountWidth-1:0]   content_count;
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        term;
  } result_t;

  typedef struct packed {
    logic psend;
    logic caps;
    logic timer;
    logic echo;
  } flags_t;

  function automatic logic [7:0] echo_form(input logic [7:0] b);
    logic [6:0] v;
    v = b[6:0];
    if ((v >= 7'h41 && v <= 7'h5a) || (v >= 7'h61 && v <= 7'h7a)) begin
      v = v ^ C_SPACE;
    end
    return {1'b0, v};
  endfunction

endpackage

FILE: rtl/serial_escape_line_front_end.sv
// Top level: input register, per-item decode, state and result buffer.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid, in_stall  | req_type, rx_byte
//   out     | out_valid, out_stall| result_kind, result_byte, line_terminated,
//           |                     | psend_mode, caps_mode, timer_mode,
//           |                     | echo_mode, last_of_run
//   cfg     | cfg_wr_en           | cfg_wr_data (echo_at_reset)
//
// An item is decoded from the input register when the result buffer is empty
// or hands out its last result; it gives 0 to 3 results, one result per cycle
// from the result buffer while out_stall is low, through the single output port.
// rst is synchronous; it clears the control state, with echo taken as 1.
// One item waits in the input register while the result buffer drains.
module serial_escape_line_front_end #(
  parameter int unsigned LINE_CAPACITY = sel_pkg::DefLineCapacity
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] result_kind,
  output logic [7:0] result_byte,
  output logic       line_terminated,
  output logic       psend_mode,
  output logic       caps_mode,
  output logic       timer_mode,
  output logic       echo_mode,
  output logic       last_of_run
);

  logic                                       echo_at_reset;
  logic                                       in_v;
  logic                                       in_req;
  logic [7:0]                                 in_byte;
  sel_pkg::state_t                            state;
  sel_pkg::state_t                            state_next;
  sel_pkg::result_t [sel_pkg::MaxResults-1:0] res;
  logic [1:0]                                 res_count;
  sel_pkg::result_t [sel_pkg::MaxResults-1:0] buf_res;
  sel_pkg::flags_t                            buf_flags;
  logic [1:0]                                 cnt;
  logic [1:0]                                 pos;
  logic                                       out_take;
  logic                                       out_last;
  logic                                       dec_fire;
  sel_pkg::result_t                           cur;

  sel_decode #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_decode (
    .state        (state),
    .echo_at_reset(echo_at_reset),
    .req_type     (in_req),
    .rx_byte      (in_byte),
    .state_next   (state_next),
    .res          (res),
    .res_count    (res_count)
  );

  assign out_valid = (cnt != 2'd0);
  assign out_last  = (pos == cnt - 2'd1);
  assign out_take  = out_valid && !out_stall;
  assign dec_fire  = in_v && (!out_valid || (out_take && out_last));
  assign in_stall  = in_v && !dec_fire;

  assign cur             = buf_res[pos];
  assign result_kind     = cur.kind;
  assign result_byte     = cur.data;
  assign line_terminated = cur.term;
  assign psend_mode      = buf_flags.psend;
  assign caps_mode       = buf_flags.caps;
  assign timer_mode      = buf_flags.timer;
  assign echo_mode       = buf_flags.echo;
  assign last_of_run     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_at_reset <= 1'b1;
    end else if (cfg_wr_en) begin
      echo_at_reset <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v <= 1'b1;
    end else if (dec_fire) begin
      in_v <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      in_req  <= req_type;
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: sel_pkg::PH_IDLE, echo: 1'b1, psend: 1'b0, caps: 1'b0,
                 timer: 1'b1, line_count: '0, content_count: '0};
    end else if (dec_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      pos <= 2'd0;
    end else if (dec_fire) begin
      cnt <= res_count;
      pos <= 2'd0;
    end else if (out_take) begin
      if (out_last) begin
        cnt <= 2'd0;
        pos <= 2'd0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
    if (dec_fire) begin
      buf_res   <= res;
      buf_flags <= '{psend: state_next.psend, caps: state_next.caps,
                     timer: state_next.timer, echo: state_next.echo};
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pos < cnt) && (cnt <= 2'd3))
    else $error("result position beyond buffered count");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (in_v && !dec_fire) |=> in_v && $stable(in_byte) && $stable(in_req))
    else $error("held input item lost or changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (state.phase == sel_pkg::PH_IDLE) && !out_valid && !in_v)
    else $error("reset did not clear control state");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (out_take && out_last && !dec_fire) |=> !out_valid)
    else $error("result buffer not empty after last transfer");

  a_no_fire_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !dec_fire)
    else $error("decode overwrote a stalled result");

endmodule

FILE: rtl/sel_decode.sv
// Per-item decode: next state and up to three results from one input item.
module sel_decode #(
  parameter int unsigned LINE_CAPACITY = sel_pkg::DefLineCapacity
) (
  input  sel_pkg::state_t                            state,
  input  logic                                       echo_at_reset,
  input  logic                                       req_type,
  input  logic [7:0]                                 rx_byte,
  output sel_pkg::state_t                            state_next,
  output sel_pkg::result_t [sel_pkg::MaxResults-1:0] res,
  output logic [1:0]                                 res_count
);

  localparam logic [sel_pkg::CountWidth-1:0] Cap = sel_pkg::CountWidth'(LINE_CAPACITY);

  always_comb begin
    logic [6:0]                      v;
    logic [1:0]                      n;
    logic                            ended;
    logic [6:0]                      code;
    logic [sel_pkg::CountWidth-1:0]  lc_inc;
    v          = rx_byte[6:0];
    n          = 2'd0;
    ended      = 1'b0;
    code       = v;
    lc_inc     = '0;
    state_next = state;
    res        = '0;

    if (req_type) begin
      if (state.timer && state.line_count != '0 && state.phase == sel_pkg::PH_IDLE) begin
        res[n] = '{kind: sel_pkg::K_LINE_END, data: 8'd0, term: 1'b0};
        n = n + 2'd1;
        state_next.line_count    = '0;
        state_next.content_count = '0;
      end
    end else if (rx_byte == 8'd0) begin
      res[n] = '{kind: sel_pkg::K_BREAK, data: 8'd0, term: 1'b0};
      n = n + 2'd1;
    end else begin
      unique case (state.phase)
        sel_pkg::PH_CMD: begin
          state_next.phase = sel_pkg::PH_IDLE;
          unique case (v)
            sel_pkg::C_PSEND_ON: state_next.psend = 1'b1;
            sel_pkg::C_PSEND_OF: state_next.psend = 1'b0;
            sel_pkg::C_ECHO_ON:  state_next.echo  = 1'b1;
            sel_pkg::C_ECHO_OF:  state_next.echo  = 1'b0;
            sel_pkg::C_CAPS_ON:  state_next.caps  = 1'b1;
            sel_pkg::C_CAPS_OF:  state_next.caps  = 1'b0;
            sel_pkg::C_TIMER_OF: state_next.timer = 1'b0;
            default: ;
          endcase
          if (v == sel_pkg::C_RESET) begin
            state_next = '{phase: sel_pkg::PH_IDLE, echo: echo_at_reset, psend: 1'b0,
                           caps: 1'b0, timer: 1'b1, line_count: '0, content_count: '0};
            res[n] = '{kind: sel_pkg::K_RESET, data: 8'd0, term: 1'b0};
            n = n + 2'd1;
            ended = 1'b1;
          end else if (v == sel_pkg::C_CURSOR_Y || v == sel_pkg::C_CURSOR_E) begin
            state_next.phase = sel_pkg::PH_ROW;
          end else begin
            if (v >= sel_pkg::C_RESP_LO && v < sel_pkg::C_RESP_HI) begin
              code = v + 7'd1;
            end else if (v > sel_pkg::C_RESP_HI) begin
              code = 7'd0;
            end
            if (state_next.echo) begin
              res[n] = '{kind: sel_pkg::K_RESPONSE, data: {1'b0, code}, term: 1'b0};
              n = n + 2'd1;
            end
          end
        end
        sel_pkg::PH_ROW: begin
          if (state.echo) begin
            res[n] = '{kind: sel_pkg::K_ECHO, data: sel_pkg::echo_form(rx_byte), term: 1'b0};
            n = n + 2'd1;
          end
          state_next.phase = sel_pkg::PH_COL;
        end
        sel_pkg::PH_COL: begin
          if (state.echo) begin
            res[n] = '{kind: sel_pkg::K_ECHO, data: sel_pkg::echo_form(rx_byte), term: 1'b0};
            n = n + 2'd1;
            res[n] = '{kind: sel_pkg::K_RESPONSE, data: 8'd0, term: 1'b0};
            n = n + 2'd1;
          end
          state_next.phase = sel_pkg::PH_IDLE;
        end
        default: begin
          if (state.echo) begin
            res[n] = '{kind: sel_pkg::K_ECHO, data: sel_pkg::echo_form(rx_byte), term: 1'b0};
            n = n + 2'd1;
          end
          if (v == sel_pkg::C_ESC) begin
            state_next.phase = sel_pkg::PH_CMD;
          end else if (v < sel_pkg::C_SPACE && v != sel_pkg::C_TAB) begin
            if (v == sel_pkg::C_BS && state.content_count != '0) begin
              state_next.content_count = state.content_count - 1'b1;
              res[n] = '{kind: sel_pkg::K_DELETE, data: 8'd0, term: 1'b0};
              n = n + 2'd1;
            end
            if (v == sel_pkg::C_CR || v == sel_pkg::C_LF) begin
              res[n] = '{kind: sel_pkg::K_LINE_END, data: 8'd0, term: 1'b1};
              n = n + 2'd1;
              state_next.line_count    = '0;
              state_next.content_count = '0;
              ended = 1'b1;
            end
          end else begin
            res[n] = '{kind: sel_pkg::K_APPEND, data: rx_byte, term: 1'b0};
            n = n + 2'd1;
            state_next.content_count = state.content_count + 1'b1;
          end
        end
      endcase
      if (!ended) begin
        lc_inc = state.line_count + 1'b1;
        state_next.line_count = lc_inc;
        if (lc_inc >= Cap) begin
          res[n] = '{kind: sel_pkg::K_LINE_END, data: 8'd0, term: 1'b0};
          n = n + 2'd1;
          state_next.line_count    = '0;
          state_next.content_count = '0;
        end
      end
    end
    res_count = n;
  end

endmodule

FILE: verif/tb_serial_escape_line_front_end.sv
`timescale 1ns / 1ps
// Self-checking testbench for the serial escape line front end: directed and random traffic.
module tb_serial_escape_line_front_end;

  localparam int unsigned LineCap = sel_pkg::DefLineCapacity;

  typedef struct packed {
    sel_pkg::kind_t kind;
    logic [7:0]     data;
    logic           term;
    logic           psend;
    logic           caps;
    logic           timer;
    logic           echo;
    logic           last;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       req_type = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] result_kind;
  logic [7:0] result_byte;
  logic       line_terminated;
  logic       psend_mode;
  logic       caps_mode;
  logic       timer_mode;
  logic       echo_mode;
  logic       last_of_run;

  serial_escape_line_front_end #(
    .LINE_CAPACITY(LineCap)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .result_byte(result_byte),
    .line_terminated(line_terminated),
    .psend_mode(psend_mode),
    .caps_mode(caps_mode),
    .timer_mode(timer_mode),
    .echo_mode(echo_mode),
    .last_of_run(last_of_run)
  );

  line_result_t front_end_results[$];
  line_result_t step_results[$];
  int           mismatch_count = 0;
  bit           idling = 1'b1;

  logic                           echo_cfg;
  sel_pkg::phase_t                esc_phase;
  logic                           echo_f;
  logic                           psend_f;
  logic                           caps_f;
  logic                           timer_f;
  logic [sel_pkg::CountWidth-1:0] line_cnt;
  logic [sel_pkg::CountWidth-1:0] content_cnt;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= idling && ($urandom_range(99) < 28);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    line_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (front_end_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = front_end_results.pop_front();
        check_field("result_kind", {5'd0, result_kind}, {5'd0, want.kind});
        check_field("result_byte", result_byte, want.data);
        check_field("line_terminated", {7'd0, line_terminated}, {7'd0, want.term});
        check_field("psend_mode", {7'd0, psend_mode}, {7'd0, want.psend});
        check_field("caps_mode", {7'd0, caps_mode}, {7'd0, want.caps});
        check_field("timer_mode", {7'd0, timer_mode}, {7'd0, want.timer});
        check_field("echo_mode", {7'd0, echo_mode}, {7'd0, want.echo});
        check_field("last_of_run", {7'd0, last_of_run}, {7'd0, want.last});
      end
    end
  end

  function automatic void clear_front_end();
    esc_phase   = sel_pkg::PH_IDLE;
    echo_f      = echo_cfg;
    psend_f     = 1'b0;
    caps_f      = 1'b0;
    timer_f     = 1'b1;
    line_cnt    = '0;
    content_cnt = '0;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    logic [6:0] c;
    c = b[6:0];
    if ((c >= 7'h41 && c <= 7'h5a) || (c >= 7'h61 && c <= 7'h7a)) c[5] = ~c[5];
    return {1'b0, c};
  endfunction

  function automatic void stage(input sel_pkg::kind_t k, input logic [7:0] d, input logic t);
    line_result_t r;
    r      = '0;
    r.kind = k;
    r.data = d;
    r.term = t;
    step_results.push_back(r);
  endfunction

  function automatic void stage_echo(input logic [7:0] b);
    if (echo_f) stage(sel_pkg::K_ECHO, flip_case(b), 1'b0);
  endfunction

  function automatic void decode_byte(input logic req, input logic [7:0] raw);
    logic [6:0]   c;
    logic [6:0]   code;
    logic         ended;
    line_result_t r;
    c     = raw[6:0];
    ended = 1'b0;
    if (req) begin
      if (timer_f && line_cnt != 0 && esc_phase == sel_pkg::PH_IDLE) begin
        stage(sel_pkg::K_LINE_END, 8'h00, 1'b0);
        line_cnt    = '0;
        content_cnt = '0;
      end
    end else if (raw == 8'h00) begin
      stage(sel_pkg::K_BREAK, 8'h00, 1'b0);
    end else begin
      if (esc_phase == sel_pkg::PH_CMD) begin
        code      = c;
        esc_phase = sel_pkg::PH_IDLE;
        case (c)
          sel_pkg::C_PSEND_ON: psend_f = 1'b1;
          sel_pkg::C_PSEND_OF: psend_f = 1'b0;
          sel_pkg::C_ECHO_ON:  echo_f  = 1'b1;
          sel_pkg::C_ECHO_OF:  echo_f  = 1'b0;
          sel_pkg::C_CAPS_ON:  caps_f  = 1'b1;
          sel_pkg::C_CAPS_OF:  caps_f  = 1'b0;
          sel_pkg::C_TIMER_OF: timer_f = 1'b0;
          default: ;
        endcase
        if (c == sel_pkg::C_RESET) begin
          clear_front_end();
          stage(sel_pkg::K_RESET, 8'h00, 1'b0);
          ended = 1'b1;
        end else if (c == sel_pkg::C_CURSOR_Y || c == sel_pkg::C_CURSOR_E) begin
          esc_phase = sel_pkg::PH_ROW;
        end else begin
          if (code >= sel_pkg::C_RESP_LO && code < sel_pkg::C_RESP_HI) code = code + 7'd1;
          else if (code > sel_pkg::C_RESP_HI) code = '0;
          if (echo_f) stage(sel_pkg::K_RESPONSE, {1'b0, code}, 1'b0);
        end
      end else if (esc_phase == sel_pkg::PH_ROW) begin
        stage_echo(raw);
        esc_phase = sel_pkg::PH_COL;
      end else if (esc_phase == sel_pkg::PH_COL) begin
        stage_echo(raw);
        if (echo_f) stage(sel_pkg::K_RESPONSE, 8'h00, 1'b0);
        esc_phase = sel_pkg::PH_IDLE;
      end else begin
        stage_echo(raw);
        if (c == sel_pkg::C_ESC) begin
          esc_phase = sel_pkg::PH_CMD;
        end else if (c < sel_pkg::C_SPACE && c != sel_pkg::C_TAB) begin
          if (c == sel_pkg::C_BS && content_cnt != 0) begin
            content_cnt = content_cnt - 1'b1;
            stage(sel_pkg::K_DELETE, 8'h00, 1'b0);
          end
          if (c == sel_pkg::C_CR || c == sel_pkg::C_LF) begin
            stage(sel_pkg::K_LINE_END, 8'h00, 1'b1);
            line_cnt    = '0;
            content_cnt = '0;
            ended       = 1'b1;
          end
        end else begin
          stage(sel_pkg::K_APPEND, raw, 1'b0);
          content_cnt = content_cnt + 1'b1;
        end
      end
      if (!ended) begin
        line_cnt = line_cnt + 1'b1;
        if (line_cnt >= LineCap) begin
          stage(sel_pkg::K_LINE_END, 8'h00, 1'b0);
          line_cnt    = '0;
          content_cnt = '0;
        end
      end
    end
    for (int i = 0; i < step_results.size(); i++) begin
      r       = step_results[i];
      r.psend = psend_f;
      r.caps  = caps_f;
      r.timer = timer_f;
      r.echo  = echo_f;
      r.last  = (i == step_results.size() - 1);
      front_end_results.push_back(r);
    end
    step_results.delete();
  endfunction

  task automatic send_item(input logic req, input logic [7:0] b);
    while (idling && $urandom_range(99) < 28) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= req;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    decode_byte(req, b);
  endtask

  task automatic send_esc(input logic [7:0] cmd);
    send_item(1'b0, {1'b0, sel_pkg::C_ESC});
    send_item(1'b0, cmd);
  endtask

  // hold off input until every expected result is out and the block is quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (front_end_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_echo_at_reset(input logic value);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    echo_cfg = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] text_byte();
    if ($urandom_range(19) == 0) return {$urandom_range(1) == 1, sel_pkg::C_TAB};
    return {$urandom_range(1) == 1, 7'($urandom_range(8'h7e, 8'h20))};
  endfunction

  task automatic test_echo_and_append();
    send_item(1'b0, 8'h41);
    send_item(1'b0, 8'h7a);
    send_item(1'b0, 8'h20);
    send_item(1'b0, 8'h7e);
    send_item(1'b0, 8'h7f);
    send_item(1'b0, {1'b0, sel_pkg::C_TAB});
    send_item(1'b0, 8'hc1);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h01);
    send_item(1'b0, {1'b0, sel_pkg::C_CR});
  endtask

  task automatic test_line_editing();
    send_item(1'b0, {1'b0, sel_pkg::C_BS});
    send_item(1'b0, 8'h61);
    send_item(1'b0, 8'h62);
    repeat (3) send_item(1'b0, {1'b0, sel_pkg::C_BS});
    send_item(1'b0, {1'b0, sel_pkg::C_LF});
    send_item(1'b0, {1'b0, sel_pkg::C_CR});
    send_item(1'b0, 8'h00);
  endtask

  task automatic test_escape_commands();
    for (int cmd = sel_pkg::C_PSEND_ON; cmd <= sel_pkg::C_TIMER_OF; cmd++) begin
      send_esc({1'b0, 7'(cmd)});
    end
    send_esc({1'b0, sel_pkg::C_RESP_LO});
    send_esc(8'h0f);
    send_esc({1'b0, sel_pkg::C_RESP_HI});
    send_esc(8'h07);
    send_item(1'b0, {1'b0, sel_pkg::C_ESC});
    send_item(1'b0, 8'h00);
    send_item(1'b0, {1'b1, sel_pkg::C_ESC});
    send_esc({1'b0, sel_pkg::C_CURSOR_Y});
    send_item(1'b0, 8'h20);
    send_item(1'b0, 8'hc1);
    send_esc({1'b0, sel_pkg::C_ECHO_OF});
    send_esc({1'b1, sel_pkg::C_CURSOR_E});
    send_item(1'b0, 8'h30);
    send_item(1'b0, 8'h31);
    send_esc({1'b0, sel_pkg::C_ECHO_ON});
    send_esc({1'b0, sel_pkg::C_RESET});
  endtask

  task automatic test_idle_timeout();
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h78);
    send_item(1'b1, 8'hff);
    send_item(1'b0, {1'b0, sel_pkg::C_ESC});
    send_item(1'b1, 8'h5a);
    send_item(1'b0, {1'b0, sel_pkg::C_RESP_HI});
    send_item(1'b1, 8'h00);
    send_esc({1'b0, sel_pkg::C_TIMER_OF});
    send_item(1'b0, 8'h79);
    send_item(1'b1, 8'h00);
    send_esc({1'b0, sel_pkg::C_RESET});
  endtask

  task automatic test_config_register();
    write_echo_at_reset(1'b0);
    send_esc({1'b0, sel_pkg::C_RESET});
    send_item(1'b0, 8'h61);
    send_esc({1'b0, sel_pkg::C_CAPS_ON});
    send_esc({1'b0, sel_pkg::C_ECHO_ON});
    send_item(1'b0, 8'h62);
    write_echo_at_reset(1'b1);
    send_esc({1'b0, sel_pkg::C_RESET});
    send_item(1'b0, 8'h63);
    send_item(1'b0, {1'b0, sel_pkg::C_CR});
  endtask

  task automatic test_line_capacity();
    idling = 1'b0;
    send_esc({1'b0, sel_pkg::C_ECHO_OF});
    send_item(1'b0, {1'b0, sel_pkg::C_CR});
    repeat (LineCap) send_item(1'b0, text_byte());
    repeat (LineCap - 1) send_item(1'b0, text_byte());
    send_item(1'b0, {1'b0, sel_pkg::C_ESC});
    send_item(1'b0, {1'b0, sel_pkg::C_CAPS_ON});
    send_esc({1'b0, sel_pkg::C_ECHO_ON});
    send_item(1'b0, {1'b0, sel_pkg::C_LF});
    idling = 1'b1;
  endtask

  task automatic test_random_traffic();
    int sent;
    int pick;
    int len;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < 400) begin
      idling = !(sent >= 150 && sent < 250);
      if (sent >= 300 && !paused) begin
        settle();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(8, 1);
        repeat (len) send_item(1'b0, text_byte());
        sent += len;
      end else if (pick < 57) begin
        send_item(1'b0, {$urandom_range(1) == 1, sel_pkg::C_ESC});
        pick = $urandom_range(99);
        if (pick < 50) begin
          send_item(1'b0, {$urandom_range(1) == 1,
                           7'($urandom_range(sel_pkg::C_CAPS_OF, sel_pkg::C_PSEND_ON))});
        end else if (pick < 55) begin
          send_item(1'b0, {1'b0, sel_pkg::C_TIMER_OF});
        end else if (pick < 65) begin
          send_item(1'b0, {$urandom_range(1) == 1, sel_pkg::C_RESET});
        end else if (pick < 82) begin
          send_item(1'b0, {$urandom_range(1) == 1,
                           ($urandom_range(1) == 1) ? sel_pkg::C_CURSOR_Y : sel_pkg::C_CURSOR_E});
          send_item(1'b0, 8'($urandom_range(255)));
          send_item(1'b0, 8'($urandom_range(255)));
          sent += 2;
        end else begin
          send_item(1'b0, 8'($urandom_range(255)));
        end
        sent += 2;
      end else if (pick < 67) begin
        send_item(1'b0, {$urandom_range(1) == 1,
                         ($urandom_range(1) == 1) ? sel_pkg::C_CR : sel_pkg::C_LF});
        sent++;
      end else if (pick < 74) begin
        send_item(1'b0, {$urandom_range(1) == 1, sel_pkg::C_BS});
        sent++;
      end else if (pick < 82) begin
        send_item(1'b1, 8'($urandom_range(255)));
        sent++;
      end else if (pick < 86) begin
        send_item(1'b0, 8'h00);
        sent++;
      end else begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
        sent++;
      end
    end
    idling = 1'b1;
  endtask

  initial begin
    echo_cfg = 1'b1;
    clear_front_end();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_echo_and_append();
    test_line_editing();
    test_escape_commands();
    test_idle_timeout();
    test_config_register();
    test_line_capacity();
    write_echo_at_reset(1'b0);
    send_esc({1'b0, sel_pkg::C_RESET});
    test_random_traffic();
    write_echo_at_reset(1'b1);
    send_esc({1'b0, sel_pkg::C_RESET});
    test_random_traffic();
    settle();
    if (front_end_results.size() != 0) report_mismatch("expected results left over");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
